// ----- rtl/fnpll_pkg.sv -----
`timescale 1ns / 1ps

package fnpll_pkg;

  localparam int FreqW = 13;

  // word slots, in the order they leave the block
  localparam logic [3:0] SLOT_R75 = 4'd0;
  localparam logic [3:0] SLOT_R45 = 4'd1;
  localparam logic [3:0] SLOT_R38 = 4'd2;
  localparam logic [3:0] SLOT_R39 = 4'd3;
  localparam logic [3:0] SLOT_R42 = 4'd4;
  localparam logic [3:0] SLOT_R43 = 4'd5;
  localparam logic [3:0] SLOT_R37 = 4'd6;
  localparam logic [3:0] SLOT_R44 = 4'd7;
  localparam logic [3:0] SLOT_R36 = 4'd8;
  localparam logic [3:0] SLOT_R0  = 4'd9;

  // configuration register indexes
  localparam logic [2:0] CFG_FPD       = 3'd0;
  localparam logic [2:0] CFG_DEN       = 3'd1;
  localparam logic [2:0] CFG_MIN_FREQ  = 3'd2;
  localparam logic [2:0] CFG_MAX_FREQ  = 3'd3;
  localparam logic [2:0] CFG_DELAY_THR = 3'd4;

  localparam logic [7:0]  ADDR_R75 = 8'd75;
  localparam logic [7:0]  ADDR_R45 = 8'd45;
  localparam logic [7:0]  ADDR_R38 = 8'd38;
  localparam logic [7:0]  ADDR_R39 = 8'd39;
  localparam logic [7:0]  ADDR_R42 = 8'd42;
  localparam logic [7:0]  ADDR_R43 = 8'd43;
  localparam logic [7:0]  ADDR_R36 = 8'd36;

  localparam logic [15:0] R75_BASE    = 16'h0800;
  localparam logic [15:0] R45_BASE    = 16'hC60F;
  localparam logic [15:0] R45_DIV1    = 16'h0800;
  localparam logic [23:0] R37_DLY3    = 24'h250305;
  localparam logic [23:0] R37_DLY2    = 24'h250205;
  localparam logic [23:0] R44_INT     = 24'h2C01A3;
  localparam logic [23:0] R44_FRAC    = 24'h2C0AA3;
  localparam logic [23:0] R0_WORD     = 24'h00211C;

  typedef struct packed {
    logic [FreqW-1:0] vco;
    logic [2:0]       lg;   // log2 of the output divider
  } carry_t;

  typedef struct packed {
    logic [15:0]      n;
    logic [31:0]      num;
    logic [FreqW-1:0] vco;
    logic [2:0]       lg;
  } rec_t;

  function automatic logic [4:0] divider_code(input logic [2:0] lg);
    logic [4:0] code;
    unique case (lg)
      3'd2:    code = 5'd1;
      3'd3:    code = 5'd3;
      3'd4:    code = 5'd5;
      3'd5:    code = 5'd7;
      3'd6:    code = 5'd9;
      3'd7:    code = 5'd12;
      default: code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/fnpll_front.sv -----
`timescale 1ns / 1ps

module fnpll_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic [15:0]              frequency_request,
  input  logic [fnpll_pkg::FreqW-1:0] min_freq,
  input  logic [fnpll_pkg::FreqW-1:0] max_freq,
  output logic                     valid_out,
  output fnpll_pkg::carry_t        carry_out
);
  import fnpll_pkg::*;

  logic [FreqW-1:0] freq;
  logic [2:0]       lg;
  logic [19:0]      vco_wide;

  // when the limits cross, requests below the lower limit get it and all others the upper
  always_comb begin
    if (frequency_request < 16'(min_freq)) begin
      freq = min_freq;
    end else if (frequency_request > 16'(max_freq)) begin
      freq = max_freq;
    end else begin
      freq = frequency_request[FreqW-1:0];
    end
  end

  always_comb begin
    priority if (freq >= 13'd3200) lg = 3'd0;
    else if (freq >= 13'd1600) lg = 3'd1;
    else if (freq >= 13'd800)  lg = 3'd2;
    else if (freq >= 13'd400)  lg = 3'd3;
    else if (freq >= 13'd200)  lg = 3'd4;
    else if (freq >= 13'd100)  lg = 3'd5;
    else if (freq >= 13'd50)   lg = 3'd6;
    else                       lg = 3'd7;
  end

  // the thresholds keep the product under 2^13
  assign vco_wide = 20'(freq) << lg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_out.vco <= vco_wide[FreqW-1:0];
      carry_out.lg  <= lg;
    end
  end

endmodule

// ----- rtl/fnpll_div8.sv -----
`timescale 1ns / 1ps

module fnpll_div8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       valid_in,
  input  logic [7:0] divisor,
  input  logic [7:0] rem_in,
  input  logic [7:0] bits_in,
  output logic       valid_out,
  output logic [7:0] quo,
  output logic [7:0] rem_out
);

  logic [8:0] r;
  logic [7:0] q;

  // eight restoring steps; rem_in is below divisor on entry
  always_comb begin
    r = {1'b0, rem_in};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[7:0], bits_in[i]};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        q[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo     <= q;
      rem_out <= r[7:0];
    end
  end

endmodule

// ----- rtl/fnpll_words.sv -----
`timescale 1ns / 1ps

module fnpll_words (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rec_valid,
  input  fnpll_pkg::rec_t             rec_in,
  output logic                        rec_ready,
  input  logic [31:0]                 den,
  input  logic [fnpll_pkg::FreqW-1:0] delay_thr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [23:0]                 register_word,
  output logic                        last_word
);
  import fnpll_pkg::*;

  logic       full;
  logic [3:0] count;
  rec_t       rec;
  logic       out_accept;

  assign out_accept = full && !out_stall;
  assign last_word  = (count == SLOT_R0);
  assign out_valid  = full;
  assign rec_ready  = !full || (out_accept && last_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      count <= SLOT_R75;
    end else if (rec_valid && rec_ready) begin
      full  <= 1'b1;
      count <= SLOT_R75;
    end else if (out_accept) begin
      if (last_word) begin
        full <= 1'b0;
      end else begin
        count <= count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      rec <= rec_in;
    end
  end

  always_comb begin
    unique case (count)
      SLOT_R75: register_word = {ADDR_R75,
                                 R75_BASE | {5'd0, divider_code(rec.lg), 6'd0}};
      SLOT_R45: register_word = {ADDR_R45,
                                 R45_BASE | ((rec.lg == 3'd0) ? R45_DIV1 : 16'd0)};
      SLOT_R38: register_word = {ADDR_R38, den[31:16]};
      SLOT_R39: register_word = {ADDR_R39, den[15:0]};
      SLOT_R42: register_word = {ADDR_R42, rec.num[31:16]};
      SLOT_R43: register_word = {ADDR_R43, rec.num[15:0]};
      SLOT_R37: register_word = (rec.vco >= delay_thr) ? R37_DLY3 : R37_DLY2;
      SLOT_R44: register_word = (rec.num == 32'd0) ? R44_INT : R44_FRAC;
      SLOT_R36: register_word = {ADDR_R36, rec.n};
      SLOT_R0:  register_word = R0_WORD;
      default:  register_word = R0_WORD;
    endcase
  end

endmodule

// ----- rtl/fracn_pll_register_planner_top.sv -----
`timescale 1ns / 1ps
// A request passes the front stage, N dividers, product register, numerator
// dividers and word register before its first word shows. Throughput: one word per
// cycle while out_stall is low, ten words per request; the output channel sets the
// request rate. Up to nine requests in flight; input takes one per cycle until full.
// Reset (synchronous, rst high) empties the pipe and restores the config registers.
module fracn_pll_register_planner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] frequency_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] register_word,
  output logic        last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fnpll_pkg::*;

  logic [7:0]       phase_detector_mhz;
  logic [31:0]      fraction_denominator;
  logic [FreqW-1:0] min_frequency_mhz;
  logic [FreqW-1:0] max_frequency_mhz;
  logic [FreqW-1:0] delay_threshold_mhz;
  logic [7:0]       fpd;

  logic   adv;
  logic   rec_ready;
  logic   v1, v2, v3, v4, v5, v6, v7, v8;
  carry_t c1, c2, c3, c4, c5, c6, c7, c8;
  logic [7:0]  qa2, qa3, qb3, rem2, rem3;
  logic [15:0] n4, n5, n6, n7, n8;
  logic [39:0] prod4;
  logic [23:0] p5;
  logic [15:0] p6;
  logic [7:0]  p7;
  logic [7:0]  q5, q6, q7, q8, r5, r6, r7, r8;
  logic [7:0]  num6;
  logic [15:0] num7;
  logic [23:0] num8;
  rec_t        rec;

  assign cfg_ready = 1'b1;
  assign fpd       = (phase_detector_mhz == 8'd0) ? 8'd1 : phase_detector_mhz;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_detector_mhz   <= 8'd100;
      fraction_denominator <= 32'd10;
      min_frequency_mhz    <= 13'd13;
      max_frequency_mhz    <= 13'd6000;
      delay_threshold_mhz  <= 13'd4900;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FPD:       phase_detector_mhz   <= cfg_data[7:0];
        CFG_DEN:       fraction_denominator <= cfg_data;
        CFG_MIN_FREQ:  min_frequency_mhz    <= cfg_data[FreqW-1:0];
        CFG_MAX_FREQ:  max_frequency_mhz    <= cfg_data[FreqW-1:0];
        CFG_DELAY_THR: delay_threshold_mhz  <= cfg_data[FreqW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together; it holds only when the tail word cannot leave
  assign adv      = !v8 || rec_ready;
  assign in_stall = !adv;

  fnpll_front u_front (
    .clk               (clk),
    .rst               (rst),
    .en                (adv),
    .valid_in          (in_valid),
    .frequency_request (frequency_request),
    .min_freq          (min_frequency_mhz),
    .max_freq          (max_frequency_mhz),
    .valid_out         (v1),
    .carry_out         (c1)
  );

  // N = vco / fpd, high byte then low byte
  fnpll_div8 u_div_nh (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v1), .divisor (fpd),
    .rem_in (8'd0), .bits_in ({3'd0, c1.vco[FreqW-1:8]}),
    .valid_out (v2), .quo (qa2), .rem_out (rem2)
  );

  fnpll_div8 u_div_nl (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v2), .divisor (fpd),
    .rem_in (rem2), .bits_in (c2.vco[7:0]),
    .valid_out (v3), .quo (qb3), .rem_out (rem3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2    <= c1;
      c3    <= c2;
      c4    <= c3;
      c5    <= c4;
      c6    <= c5;
      c7    <= c6;
      c8    <= c7;
      qa3   <= qa2;
      n4    <= {qa3, qb3};
      n5    <= n4;
      n6    <= n5;
      n7    <= n6;
      n8    <= n7;
      prod4 <= 40'(rem3) * 40'(fraction_denominator);
      p5    <= prod4[23:0];
      p6    <= p5[15:0];
      p7    <= p6[7:0];
      num6  <= q5;
      num7  <= {num6, q6};
      num8  <= {num7, q7};
    end
  end

  // numerator = prod / fpd; the top byte of prod is already below fpd
  fnpll_div8 u_div_f3 (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v4), .divisor (fpd),
    .rem_in (prod4[39:32]), .bits_in (prod4[31:24]),
    .valid_out (v5), .quo (q5), .rem_out (r5)
  );

  fnpll_div8 u_div_f2 (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v5), .divisor (fpd),
    .rem_in (r5), .bits_in (p5[23:16]),
    .valid_out (v6), .quo (q6), .rem_out (r6)
  );

  fnpll_div8 u_div_f1 (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v6), .divisor (fpd),
    .rem_in (r6), .bits_in (p6[15:8]),
    .valid_out (v7), .quo (q7), .rem_out (r7)
  );

  fnpll_div8 u_div_f0 (
    .clk (clk), .rst (rst), .en (adv), .valid_in (v7), .divisor (fpd),
    .rem_in (r7), .bits_in (p7),
    .valid_out (v8), .quo (q8), .rem_out (r8)
  );

  assign rec.n   = n8;
  assign rec.num = {num8, q8};
  assign rec.vco = c8.vco;
  assign rec.lg  = c8.lg;

  fnpll_words u_words (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (v8),
    .rec_in        (rec),
    .rec_ready     (rec_ready),
    .den           (fraction_denominator),
    .delay_thr     (delay_threshold_mhz),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .register_word (register_word),
    .last_word     (last_word)
  );

`ifndef SYNTH
  // final remainder stays below the divisor whenever the tail is valid
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v8 |-> (r8 < fpd))
    else $error("division remainder out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v8 && out_valid))
    else $error("input stalled without a blocked tail");

  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_word) |=> out_valid)
    else $error("word sequence broken before its last word");

  a_r0_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && register_word[23:16] == 8'd0) |-> last_word)
    else $error("address zero word not flagged last");
`endif

endmodule

// ----- test/fracn_pll_register_planner_top_tb.sv -----
`timescale 1ns / 1ps

module fracn_pll_register_planner_top_tb;
  import fnpll_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldOffCycles = 300;

  // expected word layout, kept independent of the RTL package
  localparam logic [7:0]  AddrR75 = 8'd75;
  localparam logic [7:0]  AddrR45 = 8'd45;
  localparam logic [7:0]  AddrR38 = 8'd38;
  localparam logic [7:0]  AddrR39 = 8'd39;
  localparam logic [7:0]  AddrR42 = 8'd42;
  localparam logic [7:0]  AddrR43 = 8'd43;
  localparam logic [7:0]  AddrR36 = 8'd36;
  localparam logic [15:0] R75Data = 16'h0800;
  localparam logic [15:0] R45Data = 16'hC60F;
  localparam logic [15:0] R45Bypass = 16'h0800;
  localparam logic [23:0] R37Delay3 = 24'h250305;
  localparam logic [23:0] R37Delay2 = 24'h250205;
  localparam logic [23:0] R44Integer = 24'h2C01A3;
  localparam logic [23:0] R44Fraction = 24'h2C0AA3;
  localparam logic [23:0] R0Data = 24'h00211C;

  typedef struct packed {
    logic [23:0] word;
    logic        last;
  } planned_word_t;

  class register_plan_scoreboard;
    logic [7:0]    fpd;
    logic [31:0]   den;
    logic [12:0]   fmin;
    logic [12:0]   fmax;
    logic [12:0]   dly_thr;
    planned_word_t planned_words[$];
    int            errors;

    function new();
      fpd = 8'd100;
      den = 32'd10;
      fmin = 13'd13;
      fmax = 13'd6000;
      dly_thr = 13'd4900;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_FPD:       fpd = data[7:0];
        CFG_DEN:       den = data;
        CFG_MIN_FREQ:  fmin = data[12:0];
        CFG_MAX_FREQ:  fmax = data[12:0];
        CFG_DELAY_THR: dly_thr = data[12:0];
        default: ;
      endcase
    endfunction

    // works out the ten words one request should produce
    function void note_request(logic [15:0] freq);
      logic [15:0]   f;
      logic [63:0]   fpd_eff;
      logic [63:0]   vco;
      logic [63:0]   n;
      logic [63:0]   num;
      logic [4:0]    code;
      logic [23:0]   w[10];
      planned_word_t e;
      int            lg;
      int            k;
      f = freq;
      // when min exceeds max, requests below min get min and all others get max
      if (f < fmin) begin
        f = fmin;
      end else if (f > fmax) begin
        f = fmax;
      end
      if (f >= 3200) lg = 0;
      else if (f >= 1600) lg = 1;
      else if (f >= 800) lg = 2;
      else if (f >= 400) lg = 3;
      else if (f >= 200) lg = 4;
      else if (f >= 100) lg = 5;
      else if (f >= 50) lg = 6;
      else lg = 7;
      case (lg)
        2: code = 5'd1;
        3: code = 5'd3;
        4: code = 5'd5;
        5: code = 5'd7;
        6: code = 5'd9;
        7: code = 5'd12;
        default: code = 5'd0;
      endcase
      vco = 64'(f) << lg;
      fpd_eff = (fpd == 8'd0) ? 64'd1 : 64'(fpd);
      n = vco / fpd_eff;
      num = ((vco % fpd_eff) * 64'(den)) / fpd_eff;
      w[0] = {AddrR75, R75Data | {5'd0, code, 6'd0}};
      w[1] = {AddrR45, R45Data | ((lg == 0) ? R45Bypass : 16'h0000)};
      w[2] = {AddrR38, den[31:16]};
      w[3] = {AddrR39, den[15:0]};
      w[4] = {AddrR42, num[31:16]};
      w[5] = {AddrR43, num[15:0]};
      w[6] = (vco >= 64'(dly_thr)) ? R37Delay3 : R37Delay2;
      w[7] = (num == 64'd0) ? R44Integer : R44Fraction;
      w[8] = {AddrR36, n[15:0]};
      w[9] = R0Data;
      for (k = 0; k < 10; k++) begin
        e.word = w[k];
        e.last = (k == 9);
        planned_words.push_back(e);
      end
    endfunction

    function void check_word(logic [23:0] word, logic last);
      planned_word_t e;
      if (planned_words.size() == 0) begin
        errors++;
        $error("register_word: expected none, got %06h", word);
        return;
      end
      e = planned_words.pop_front();
      if (word !== e.word) begin
        errors++;
        $error("register_word: expected %06h, got %06h", e.word, word);
      end
      if (last !== e.last) begin
        errors++;
        $error("last_word: expected %0b, got %0b", e.last, last);
      end
    endfunction

    function int pending();
      return planned_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] frequency_request = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] register_word;
  logic        last_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  register_plan_scoreboard plan_board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;

  fracn_pll_register_planner_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .frequency_request (frequency_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .register_word     (register_word),
    .last_word         (last_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldOffCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      plan_board.check_word(register_word, last_word);
    end
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    plan_board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_request(input logic [15:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    frequency_request <= freq;
    do @(posedge clk); while (in_stall);
    plan_board.note_request(freq);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (plan_board.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [15:0] random_request();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(6400));
      // around one of the divider thresholds
      2: return 16'((50 << $urandom_range(6)) + $urandom_range(4) - 2);
      default: return 16'($urandom_range(120));
    endcase
  endfunction

  initial begin
    logic [15:0] edge_freqs[$];
    logic [31:0] r;
    plan_board = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 81;

    // reset settings: divider thresholds, delay threshold, clamps
    edge_freqs = '{16'd0, 16'd12, 16'd13, 16'd50, 16'd99, 16'd200, 16'd400, 16'd800,
                   16'd1600, 16'd2450, 16'd3199, 16'd3200, 16'd4910, 16'd6000,
                   16'd6001, 16'hFFFF};
    foreach (edge_freqs[i]) send_request(edge_freqs[i]);
    drain();

    // zero phase detector, widest denominator, min above max
    write_cfg(CFG_FPD, 32'hFFFF_FF00);
    write_cfg(CFG_DEN, 32'hFFFF_FFFF);
    write_cfg(CFG_MIN_FREQ, 32'd500);
    write_cfg(CFG_MAX_FREQ, 32'd300);
    write_cfg(CFG_DELAY_THR, 32'd0);
    // indexes past the last register must be ignored
    for (int i = CFG_DELAY_THR + 1; i < 8; i++) write_cfg(3'(i), 32'h0000_0001);
    cfg_valid <= 1'b0;
    edge_freqs = '{16'd0, 16'd300, 16'd499, 16'd501, 16'hFFFF};
    foreach (edge_freqs[i]) send_request(edge_freqs[i]);
    drain();

    // wide numerator
    write_cfg(CFG_FPD, 32'h0000_00FF);
    write_cfg(CFG_MAX_FREQ, 32'h0000_1FFF);
    cfg_valid <= 1'b0;
    send_request(16'd1000);
    send_request(16'd8191);
    drain();

    r = $urandom;
    r[7:0] = 8'($urandom_range(2, 255));
    write_cfg(CFG_FPD, r);
    write_cfg(CFG_DEN, $urandom);
    r = $urandom;
    r[12:0] = 13'($urandom_range(1, 60));
    write_cfg(CFG_MIN_FREQ, r);
    r = $urandom;
    r[12:0] = 13'($urandom_range(3300, 6400));
    write_cfg(CFG_MAX_FREQ, r);
    write_cfg(CFG_DELAY_THR, $urandom);
    cfg_valid <= 1'b0;
    repeat (48) send_request(random_request());
    drain();

    send_idle_pct = 81;
    recv_idle_pct = 10;
    r = $urandom;
    r[7:0] = 8'hFF;
    write_cfg(CFG_FPD, r);
    write_cfg(CFG_DEN, $urandom);
    r = $urandom;
    r[12:0] = 13'd0;
    write_cfg(CFG_MIN_FREQ, r);
    r = $urandom;
    r[12:0] = 13'h1FFF;
    write_cfg(CFG_MAX_FREQ, r);
    write_cfg(CFG_DELAY_THR, r);
    cfg_valid <= 1'b0;
    repeat (48) send_request(random_request());
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_FPD, $urandom);
    write_cfg(CFG_DEN, 32'd1);
    write_cfg(CFG_MIN_FREQ, 32'd1);
    write_cfg(CFG_MAX_FREQ, 32'd6400);
    write_cfg(CFG_DELAY_THR, $urandom);
    cfg_valid <= 1'b0;
    // receiver holds off so the pipe fills and the input stalls
    hold_req = 1'b1;
    repeat (50) send_request(random_request());
    drain();

    repeat (20) @(negedge clk);
    if (plan_board.errors == 0 && plan_board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
